FILE: sv/adcso_pkg.sv
// Shared types, constants and helpers for the ADC scan oversampling averager.
`timescale 1ns / 1ps
package adcso_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int SAMPLE_BITS_DEF  = 10;

  localparam int IDX_W         = 6;
  localparam int COUNT_W       = 4;
  localparam int SHIFT_W       = 3;
  localparam int SHIFT_MAX     = 5;
  localparam int MUX_W         = 5;
  localparam int MUX_ENTRIES   = 8;
  localparam int MUX_TABLE_W   = MUX_W * MUX_ENTRIES;
  localparam int CH_OUT_W      = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = MUX_TABLE_W;

  localparam logic [SHIFT_W-1:0] SHIFT_LIMIT   = SHIFT_W'(SHIFT_MAX);
  localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 3'd3;
  localparam logic [COUNT_W-1:0] COUNT_RESET   = 4'd1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_MUX_TABLE     = 2'd1,
    CFG_AVERAGE_SHIFT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic is_read;
    logic rd_ok;
  } ctl_t;

  function automatic logic [MUX_W-1:0] mux_of(input logic [MUX_TABLE_W-1:0] tbl,
                                               input logic [IDX_W-1:0] ch);
    logic [MUX_W-1:0] code;
    if (ch >= IDX_W'(MUX_ENTRIES)) begin
      code = '0;
    end else begin
      code = tbl[ch[2:0]*MUX_W +: MUX_W];
    end
    return code;
  endfunction

endpackage

FILE: sv/adc_scan_oversample_averager_core.sv
// Top level of the round-robin ADC scan averager with oversampling.
//
// Input channel (in_*): one beat per conversion (in_operation = sample) or per
// average read (in_operation = read, channel in in_read_channel).
// Result channel (out_*): exactly one beat per input beat, in order. A sample
// beat returns the mux code of the channel scanned next and flags a stored
// average; a read beat returns the stored average of the chosen channel.
// Configuration channel (cfg_*): always ready; index 0 channel count,
// 1 packed mux table, 2 averaging shift. Write only while the block is idle.
// Accepted beats pass the queue, then the result register. Throughput: one
// beat per cycle while out_ready is high, set by the accumulate and compare in
// the execution stage; a two-entry queue decouples acceptance from execution.
// When out_ready is low the result register holds, the queue fills, and
// in_ready drops once both entries are taken.
// Reset: synchronous, active low; clears accumulator, counters, averages and
// queue, and loads count 1, mux table 0, shift 3.
`timescale 1ns / 1ps
module adc_scan_oversample_averager_core #(
  parameter int MAX_CHANNELS = adcso_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = adcso_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [adcso_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [adcso_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [SAMPLE_BITS-1:0]            in_sample,
  input  logic [adcso_pkg::CH_OUT_W-1:0]    in_read_channel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [SAMPLE_BITS-1:0]            out_read_value,
  output logic [adcso_pkg::MUX_W-1:0]       out_mux_code,
  output logic                              out_average_stored,
  output logic [adcso_pkg::CH_OUT_W-1:0]    out_stored_channel
);
  import adcso_pkg::*;

  localparam int Q_W = $bits(ctl_t) + SAMPLE_BITS + IDX_W;

  logic                   q_full;
  logic                   q_not_empty;
  logic                   q_push;
  logic                   q_pop;
  ctl_t                   f_ctl;
  logic [SAMPLE_BITS-1:0] f_sample;
  logic [IDX_W-1:0]       f_idx;
  logic [Q_W-1:0]         q_rd_data;
  ctl_t                   b_ctl;
  logic [SAMPLE_BITS-1:0] b_sample;
  logic [IDX_W-1:0]       b_idx;

  adcso_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_sample       (in_sample),
    .in_read_channel (in_read_channel),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_ctl           (f_ctl),
    .q_sample        (f_sample),
    .q_idx           (f_idx)
  );

  adcso_fifo #(
    .DATA_W (Q_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_ctl, f_sample, f_idx}),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  assign {b_ctl, b_sample, b_idx} = q_rd_data;

  adcso_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .q_valid            (q_not_empty),
    .q_ctl              (b_ctl),
    .q_sample           (b_sample),
    .q_idx              (b_idx),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_value     (out_read_value),
    .out_mux_code       (out_mux_code),
    .out_average_stored (out_average_stored),
    .out_stored_channel (out_stored_channel)
  );

endmodule

FILE: sv/adcso_front.sv
// Front end: accepts input beats and classifies them for the execution queue.
`timescale 1ns / 1ps
module adcso_front #(
  parameter int MAX_CHANNELS = adcso_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = adcso_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic [SAMPLE_BITS-1:0]          in_sample,
  input  logic [adcso_pkg::CH_OUT_W-1:0]  in_read_channel,
  input  logic                            q_full,
  output logic                            q_push,
  output adcso_pkg::ctl_t                 q_ctl,
  output logic [SAMPLE_BITS-1:0]          q_sample,
  output logic [adcso_pkg::IDX_W-1:0]     q_idx
);
  import adcso_pkg::*;

  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_CHANNELS);

  assign in_ready       = !q_full;
  assign q_push         = in_valid && !q_full;
  assign q_idx          = IDX_W'(in_read_channel);
  assign q_ctl.is_read  = (in_operation == OP_READ);
  assign q_ctl.rd_ok    = (IDX_W'(in_read_channel) < MAX_IDX);
  assign q_sample       = in_sample;

endmodule

FILE: sv/adcso_fifo.sv
// Two-entry queue between the front end and the execution stage.
`timescale 1ns / 1ps
module adcso_fifo #(
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              full,
  output logic              not_empty
);

  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/adcso_back.sv
// Execution stage: configuration, accumulation, average store and result register.
`timescale 1ns / 1ps
module adcso_back #(
  parameter int MAX_CHANNELS = adcso_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = adcso_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [adcso_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [adcso_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              q_valid,
  input  adcso_pkg::ctl_t                   q_ctl,
  input  logic [SAMPLE_BITS-1:0]            q_sample,
  input  logic [adcso_pkg::IDX_W-1:0]       q_idx,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [SAMPLE_BITS-1:0]            out_read_value,
  output logic [adcso_pkg::MUX_W-1:0]       out_mux_code,
  output logic                              out_average_stored,
  output logic [adcso_pkg::CH_OUT_W-1:0]    out_stored_channel
);
  import adcso_pkg::*;

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ACC_W = SAMPLE_BITS + SHIFT_MAX;
  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_CHANNELS);

  logic [COUNT_W-1:0]     count_r;
  logic [MUX_TABLE_W-1:0] mux_r;
  logic [SHIFT_W-1:0]     shift_r;

  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [IDX_W-1:0]       cnt_r, cnt_nxt;
  logic [CH_W-1:0]        cur_r, cur_nxt;
  logic [SAMPLE_BITS-1:0] avg_r [MAX_CHANNELS];

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] read_value_r, read_value_nxt;
  logic [MUX_W-1:0]       mux_code_r;
  logic                   stored_r;
  logic [CH_OUT_W-1:0]    stored_ch_r;

  logic                   exec;
  logic                   store;
  logic [IDX_W-1:0]       target;
  logic [IDX_W-1:0]       eff;
  logic [IDX_W-1:0]       ch_inc;
  logic [ACC_W-1:0]       acc_shifted;
  logic [SAMPLE_BITS-1:0] avg_new;
  logic [SHIFT_W-1:0]     shift_in;

  assign cfg_ready = 1'b1;
  assign exec      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = exec;

  always_comb begin
    target      = IDX_W'(1) << shift_r;
    store       = exec && !q_ctl.is_read && (cnt_r >= target);
    ch_inc      = IDX_W'(cur_r) + IDX_W'(1);
    eff         = (count_r == '0) ? IDX_W'(1) : IDX_W'(count_r);
    if (eff > MAX_IDX) begin
      eff = MAX_IDX;
    end
    acc_shifted = acc_r >> shift_r;
    avg_new     = acc_shifted[SAMPLE_BITS-1:0];

    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    cur_nxt = cur_r;
    if (store) begin
      acc_nxt = '0;
      cnt_nxt = '0;
      cur_nxt = (ch_inc >= eff) ? '0 : ch_inc[CH_W-1:0];
    end else if (exec && !q_ctl.is_read) begin
      acc_nxt = acc_r + ACC_W'(q_sample);
      cnt_nxt = cnt_r + IDX_W'(1);
    end

    read_value_nxt = '0;
    if (q_ctl.is_read && q_ctl.rd_ok) begin
      read_value_nxt = avg_r[q_idx[CH_W-1:0]];
    end

    shift_in = (cfg_data[SHIFT_W-1:0] > SHIFT_LIMIT) ? SHIFT_LIMIT : cfg_data[SHIFT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
      mux_r   <= '0;
      shift_r <= SHIFT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT: count_r <= cfg_data[COUNT_W-1:0];
        CFG_MUX_TABLE:     mux_r   <= cfg_data[MUX_TABLE_W-1:0];
        CFG_AVERAGE_SHIFT: shift_r <= shift_in;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      cur_r <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        avg_r[i] <= '0;
      end
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      cur_r <= cur_nxt;
      if (store) begin
        avg_r[cur_r] <= avg_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      read_value_r <= read_value_nxt;
      mux_code_r   <= mux_of(mux_r, IDX_W'(cur_nxt));
      stored_r     <= store;
      stored_ch_r  <= store ? CH_OUT_W'(cur_r) : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_value     = read_value_r;
  assign out_mux_code       = mux_code_r;
  assign out_average_stored = stored_r;
  assign out_stored_channel = stored_ch_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= IDX_W'(32))
    else $error("sample count above limit");

  a_channel_bound: assert property (@(posedge clk) disable iff (!rst_n)
    IDX_W'(cur_r) < MAX_IDX)
    else $error("current channel out of range");

  a_store_clears: assert property (@(posedge clk) disable iff (!rst_n)
    store |=> (cnt_r == '0) && (acc_r == '0))
    else $error("accumulator not cleared after store");

  a_store_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && stored_r) |-> (read_value_r == '0))
    else $error("store beat carries a read value");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> !$past(exec) || $past(q_valid))
    else $error("result register overwritten under stall");

endmodule
